### sv/frcs_pkg.sv
// Package for the Floyd combination sampler: sizes, register index codes,
// controller state encoding and the command/status structs.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package frcs_pkg;

  // Sizing of the block.
  localparam int MAX_PICKS     = 64;
  localparam int INDEX_BITS    = 24;
  localparam int FRAC_BITS     = 32;
  localparam int PICK_CFG_BITS = 7;

  // Derived widths.
  localparam int CNT_BITS      = $clog2(MAX_PICKS + 1);
  localparam int ADDR_BITS     = (MAX_PICKS > 1) ? $clog2(MAX_PICKS) : 1;
  localparam int ELEM_BITS     = INDEX_BITS + 1;
  localparam int CFG_BITS      = (INDEX_BITS > PICK_CFG_BITS) ? INDEX_BITS : PICK_CFG_BITS;
  localparam int IN_DATA_BITS  = ((FRAC_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((ELEM_BITS + 7) / 8) * 8;
  localparam int CMP_BITS      = ((INDEX_BITS > CNT_BITS) ? INDEX_BITS : CNT_BITS) + 1;
  localparam int PROD_BITS     = FRAC_BITS + INDEX_BITS + 1;
  localparam int CFG_IDX_BITS  = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_BASE_OFFSET = 2'd0,
    CFG_SET_SIZE    = 2'd1,
    CFG_PICK_COUNT  = 2'd2
  } cfg_idx_t;

  // Controller states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_CMP  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul;
    logic cmp;
    logic commit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

### sv/frcs_ctrl.sv
// Controller of the Floyd combination sampler: sequences accept, multiply,
// compare and commit for one draw at a time.
// Depends on frcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frcs_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  input  frcs_pkg::dp_status_t  status,
  output frcs_pkg::dp_cmd_t     cmd
);
  import frcs_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // Next-state logic and command decode.
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // Hold until the output register can take the result.
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/frcs_datapath.sv
// Datapath of the Floyd combination sampler: configuration registers, the
// scaling multiply, the row of pick cells with their comparators, and the
// output register. Depends on frcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frcs_datapath (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_wr_en,
  input  wire  [frcs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire  [frcs_pkg::CFG_BITS-1:0]        cfg_wdata,
  input  wire  [frcs_pkg::IN_DATA_BITS-1:0]    in_tdata,
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [frcs_pkg::OUT_DATA_BITS-1:0]   out_tdata,
  output logic                                 out_tlast,
  input  frcs_pkg::dp_cmd_t                    cmd,
  output frcs_pkg::dp_status_t                 status
);
  import frcs_pkg::*;

  // Configuration registers.
  logic [INDEX_BITS-1:0]    base_r;
  logic [INDEX_BITS-1:0]    size_r;
  logic [PICK_CFG_BITS-1:0] kcfg_r;

  // Run position; equals the number of filled pick cells.
  logic [CNT_BITS-1:0]      pos_r;
  logic [CNT_BITS-1:0]      pos_nxt;

  // Per-draw working registers.
  logic [FRAC_BITS-1:0]     frac_r;
  logic [INDEX_BITS-1:0]    j_r;
  logic                     last_r;
  logic [INDEX_BITS-1:0]    t_r;
  logic [ELEM_BITS-1:0]     cand_r;
  logic [ELEM_BITS-1:0]     jb_r;
  logic [MAX_PICKS-1:0]     match_r;

  // Row of pick cells, each with its own comparator.
  logic [ELEM_BITS-1:0]     store_r [MAX_PICKS];

  // Output register.
  logic                     out_valid_r;
  logic [ELEM_BITS-1:0]     out_data_r;
  logic                     out_last_r;

  // Combinational terms.
  logic [INDEX_BITS-1:0]    n_eff;
  logic [PICK_CFG_BITS-1:0] k_cfg;
  logic [CMP_BITS-1:0]      k_eff;
  logic [CMP_BITS-1:0]      pos_wide;
  logic [CNT_BITS-1:0]      pos_eff;
  logic [INDEX_BITS-1:0]    j_acc;
  logic                     last_acc;
  logic [PROD_BITS-1:0]     prod;
  logic [ELEM_BITS-1:0]     cand;
  logic [ELEM_BITS-1:0]     pick;
  logic                     out_free;

  // Effective set size and pick count: zero acts as one, k is clamped to n
  // and to the number of pick cells.
  always_comb begin
    n_eff = (size_r == '0) ? INDEX_BITS'(1) : size_r;
    k_cfg = (kcfg_r == '0) ? PICK_CFG_BITS'(1) : kcfg_r;
    k_eff = CMP_BITS'(k_cfg);
    if (CMP_BITS'(n_eff) < k_eff) begin
      k_eff = CMP_BITS'(n_eff);
    end
    if (CMP_BITS'(MAX_PICKS) < k_eff) begin
      k_eff = CMP_BITS'(MAX_PICKS);
    end
  end

  // A stale position restarts the run with an empty row.
  assign pos_wide = CMP_BITS'(pos_r);
  assign pos_eff  = (pos_wide >= k_eff) ? '0 : pos_r;
  assign j_acc    = n_eff - INDEX_BITS'(k_eff) + INDEX_BITS'(pos_eff);
  assign last_acc = (CMP_BITS'(pos_eff) + CMP_BITS'(1)) == k_eff;

  // Scaling multiply: t = floor(f * (j + 1) / 2^32), never above j.
  assign prod = PROD_BITS'(frac_r) * PROD_BITS'({1'b0, j_r} + ELEM_BITS'(1));

  assign cand = ELEM_BITS'(t_r) + ELEM_BITS'(base_r);

  // A candidate already in the row falls back to j plus the offset.
  assign pick     = (|match_r) ? jb_r : cand_r;
  assign out_free = !out_valid_r || out_tready;

  assign status.out_free = out_free;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      size_r <= INDEX_BITS'(1);
      kcfg_r <= PICK_CFG_BITS'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_BASE_OFFSET: base_r <= cfg_wdata[INDEX_BITS-1:0];
        CFG_SET_SIZE:    size_r <= cfg_wdata[INDEX_BITS-1:0];
        CFG_PICK_COUNT:  kcfg_r <= cfg_wdata[PICK_CFG_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Run position: any valid register write re-arms the run.
  always_comb begin
    pos_nxt = pos_r;
    if (cfg_wr_en && (cfg_index == CFG_BASE_OFFSET || cfg_index == CFG_SET_SIZE ||
                      cfg_index == CFG_PICK_COUNT)) begin
      pos_nxt = '0;
    end else if (cmd.load) begin
      pos_nxt = pos_eff;
    end else if (cmd.commit) begin
      pos_nxt = last_r ? '0 : pos_r + CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // Draw pipeline registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      frac_r <= in_tdata[FRAC_BITS-1:0];
      j_r    <= j_acc;
      last_r <= last_acc;
    end
    if (cmd.mul) begin
      t_r <= prod[FRAC_BITS +: INDEX_BITS];
    end
    if (cmd.cmp) begin
      cand_r <= cand;
      jb_r   <= ELEM_BITS'(j_r) + ELEM_BITS'(base_r);
      for (int i = 0; i < MAX_PICKS; i++) begin
        match_r[i] <= (store_r[i] == cand) && (CNT_BITS'(i) < pos_r);
      end
    end
  end

  // Pick cells: the pick is stored unless it closes the run.
  always_ff @(posedge clk) begin
    if (cmd.commit && !last_r) begin
      store_r[pos_r[ADDR_BITS-1:0]] <= pick;
    end
  end

  // Output register; a waiting result holds only the next draw's commit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= pick;
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_BITS'(out_data_r);
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  // The run never fills every cell before its last pick.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < CNT_BITS'(MAX_PICKS))
    else $error("run position reached the pick cell count");

  // Only filled cells may report a match.
  a_match_filled: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> ((match_r >> pos_r) == '0))
    else $error("match from an unfilled pick cell");

  // The last pick of a run re-arms the position.
  a_last_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && last_r && !cfg_wr_en) |=> (pos_r == '0))
    else $error("run not re-armed after its last pick");

  // A result is never committed over one still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_tready))
    else $error("result committed over a waiting transfer");
`endif

endmodule

`default_nettype wire

### sv/floyd_random_combination_sampler_core.sv
// Top level of the Floyd combination sampler: joins the controller and the
// datapath. Depends on frcs_pkg, frcs_ctrl and frcs_datapath.
//
//   Channel   Direction  Handshake          Contents
//   in_       slave      tvalid/tready      tdata[31:0]: random_fraction
//   out_      master     tvalid/tready      tdata[24:0]: chosen_element; tlast: last_pick
//   cfg_      write      wr_en              index: register; wdata: value
//
// Each draw passes through four steps: accept, scaling multiply, compare against all
// filled pick cells in parallel, then select and commit into the output register.
// Synchronous active-low reset clears control, config, run position and out_tvalid.
// A result waiting on out_tready holds only the commit cycle; the next draw is
// accepted as soon as its predecessor is committed.
`timescale 1ns / 1ps
`default_nettype none

module floyd_random_combination_sampler_core (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // Configuration write port.
  input  wire                                 cfg_wr_en,
  input  wire  [frcs_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire  [frcs_pkg::CFG_BITS-1:0]       cfg_wdata,
  // Input stream.
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [frcs_pkg::IN_DATA_BITS-1:0]   in_tdata,   // [31:0] random_fraction
  // Result stream.
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [frcs_pkg::OUT_DATA_BITS-1:0]  out_tdata,  // [24:0] chosen_element
  output logic                                out_tlast
);
  import frcs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencing of one draw.
  frcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic, pick cells and output register.
  frcs_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

`default_nettype wire
